// ----- rtl/pifmt_pkg.sv -----
package pifmt_pkg;

  localparam int FW_BITS   = 6;
  localparam int ND_BITS   = 5;
  localparam int NDIG      = 20;
  localparam int HEX_DIGS  = 16;
  localparam int DAB_STEPS = 32;

  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_NORM, ST_PREC, ST_PAD, ST_LPAD,
    ST_SIGN, ST_ZPAD, ST_ZPREC, ST_DIG, ST_TPAD
  } step_t;

  typedef enum logic [2:0] {
    OP_WAIT, OP_DABBLE, OP_NORM, OP_PREC, OP_PAD, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_INVALID, COND_CONV, COND_NORM, COND_NONE, COND_LPAD,
    COND_SIGN, COND_ZPAD, COND_ZPREC, COND_DIG, COND_TPAD
  } cond_t;

  typedef enum logic [1:0] {
    SRC_SPACE, SRC_MINUS, SRC_ZERO, SRC_DIGIT
  } src_t;

  // one control word: what to do, how long to repeat it, which character to emit, where to go next
  typedef struct packed {
    op_t   op;
    cond_t cnd;
    src_t  src;
    step_t nxt;
  } ctrl_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift;
  } dig_cmd_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    unique case (s)
      ST_IDLE:  c = '{OP_WAIT,   COND_INVALID, SRC_SPACE, ST_CONV};
      ST_CONV:  c = '{OP_DABBLE, COND_CONV,    SRC_SPACE, ST_NORM};
      ST_NORM:  c = '{OP_NORM,   COND_NORM,    SRC_SPACE, ST_PREC};
      ST_PREC:  c = '{OP_PREC,   COND_NONE,    SRC_SPACE, ST_PAD};
      ST_PAD:   c = '{OP_PAD,    COND_NONE,    SRC_SPACE, ST_LPAD};
      ST_LPAD:  c = '{OP_EMIT,   COND_LPAD,    SRC_SPACE, ST_SIGN};
      ST_SIGN:  c = '{OP_EMIT,   COND_SIGN,    SRC_MINUS, ST_ZPAD};
      ST_ZPAD:  c = '{OP_EMIT,   COND_ZPAD,    SRC_ZERO,  ST_ZPREC};
      ST_ZPREC: c = '{OP_EMIT,   COND_ZPREC,   SRC_ZERO,  ST_DIG};
      ST_DIG:   c = '{OP_EMIT,   COND_DIG,     SRC_DIGIT, ST_TPAD};
      ST_TPAD:  c = '{OP_EMIT,   COND_TPAD,    SRC_SPACE, ST_IDLE};
      default:  c = '{OP_WAIT,   COND_INVALID, SRC_SPACE, ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/pifmt_if.sv -----
interface pifmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] value;
  logic        left_align;
  logic        zero_pad;
  logic [5:0]  field_width;
  logic        precision_given;
  logic [5:0]  precision;

  modport source (
    output valid, mode, value, left_align, zero_pad, field_width,
           precision_given, precision,
    input  ready
  );
  modport sink (
    input  valid, mode, value, left_align, zero_pad, field_width,
           precision_given, precision,
    output ready
  );
endinterface

interface pifmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface

// ----- rtl/pifmt_digits.sv -----
module pifmt_digits (
  input  logic                clk,
  input  pifmt_pkg::dig_cmd_t cmd,
  input  logic [63:0]         mag,
  output logic [3:0]          top
);

  localparam int DW = 4 * pifmt_pkg::NDIG;

  logic [DW-1:0] dig_r;
  logic [63:0]   bin_r;

  // add-3 on every bcd digit of five or more, then shift one binary bit in
  function automatic logic [DW-1:0] dab(input logic [DW-1:0] d, input logic b);
    logic [DW-1:0] a;
    a = d;
    for (int k = 0; k < pifmt_pkg::NDIG; k++) begin
      if (d[4*k +: 4] >= 4'd5) a[4*k +: 4] = d[4*k +: 4] + 4'd3;
    end
    return {a[DW-2:0], b};
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_dec) begin
      dig_r <= '0;
      bin_r <= mag;
    end else if (cmd.load_hex) begin
      dig_r <= {mag, {(DW-64){1'b0}}};
    end else if (cmd.dabble) begin
      dig_r <= dab(dab(dig_r, bin_r[63]), bin_r[62]);
      bin_r <= {bin_r[61:0], 2'b00};
    end else if (cmd.shift) begin
      dig_r <= {dig_r[DW-5:0], 4'h0};
    end
  end

  assign top = dig_r[DW-1 -: 4];

endmodule

// ----- rtl/printf_integer_field_formatter.sv -----
// channel  | dir | beat carries
// in_if    | in  | mode, value, left_align, zero_pad, field_width, precision_given, precision
// out_if   | out | out_char, last (one beat per character)
//
// one item at a time; a microcoded sequencer walks conversion, sizing and emission
// decimal: double dabble (two bits a cycle) then a step to leave, hex: loaded as digits, a step to leave
// then leading zero digits are dropped, one per cycle, then the sizing steps PREC and PAD,
// then six emission steps, one character per cycle while out_if.ready does not hold them off
// rst_n is synchronous; out_if.ready low holds the sequencer on the pending character
module printf_integer_field_formatter #(
  parameter int MAX_FIELD = 63
) (
  input logic         clk,
  input logic         rst_n,
  pifmt_in_if.sink    in_if,
  pifmt_out_if.source out_if
);

  localparam logic [5:0] WIDTH_MAX = 6'(MAX_FIELD);
  localparam logic [5:0] PREC_MAX  = 6'(MAX_FIELD - 1);

  pifmt_pkg::step_t    step_r, step_nxt;
  pifmt_pkg::ctrl_t    cw;
  pifmt_pkg::dig_cmd_t dcmd;

  logic                          neg_r, left_r, zero_r, pgiven_r, supp_r;
  logic [pifmt_pkg::FW_BITS-1:0] width_r, prec_r, zprec_r;
  logic [pifmt_pkg::FW_BITS-1:0] lpad_r, zpad_r, tpad_r, rem_r;
  logic [pifmt_pkg::ND_BITS-1:0] nd_r;
  logic [5:0]                    conv_cnt_r;
  logic                          out_valid_r, out_last_r;
  logic [7:0]                    out_char_r;

  logic        accept, hex, neg_in, cond, out_free, fire;
  logic [63:0] mag;
  logic [3:0]  top;
  logic [7:0]  ch;
  logic [6:0]  core;
  logic [pifmt_pkg::ND_BITS-1:0] nd_eff;

  assign cw     = pifmt_pkg::ucode(step_r);
  assign accept = in_if.valid && in_if.ready;
  assign hex    = (in_if.mode == pifmt_pkg::MODE_HEX);
  assign neg_in = (in_if.mode == pifmt_pkg::MODE_SDEC) && in_if.value[63];
  assign mag    = neg_in ? (~in_if.value + 64'd1) : in_if.value;

  pifmt_digits u_digits (
    .clk (clk),
    .cmd (dcmd),
    .mag (mag),
    .top (top)
  );

  always_comb begin
    unique case (cw.cnd)
      pifmt_pkg::COND_INVALID: cond = !in_if.valid;
      pifmt_pkg::COND_CONV:    cond = (conv_cnt_r != 6'd0);
      pifmt_pkg::COND_NORM:    cond = (nd_r > 5'd1) && (top == 4'h0);
      pifmt_pkg::COND_NONE:    cond = 1'b0;
      pifmt_pkg::COND_LPAD:    cond = (lpad_r != '0);
      pifmt_pkg::COND_SIGN:    cond = neg_r;
      pifmt_pkg::COND_ZPAD:    cond = (zpad_r != '0);
      pifmt_pkg::COND_ZPREC:   cond = (zprec_r != '0);
      pifmt_pkg::COND_DIG:     cond = (nd_r != '0);
      pifmt_pkg::COND_TPAD:    cond = (tpad_r != '0);
      default:                 cond = 1'b0;
    endcase
  end

  // next step: repeat while the step's condition holds
  always_comb begin
    step_nxt = cond ? step_r : cw.nxt;
  end

  always_comb begin
    out_free      = !out_valid_r || out_if.ready;
    fire          = (cw.op == pifmt_pkg::OP_EMIT) && cond && out_free;
    in_if.ready   = (cw.op == pifmt_pkg::OP_WAIT) && rst_n;
    dcmd.load_dec = accept && !hex;
    dcmd.load_hex = accept && hex;
    dcmd.dabble   = (cw.op == pifmt_pkg::OP_DABBLE) && cond;
    dcmd.shift    = ((cw.op == pifmt_pkg::OP_NORM) && cond) ||
                    (fire && (cw.src == pifmt_pkg::SRC_DIGIT));
    unique case (cw.src)
      pifmt_pkg::SRC_SPACE: ch = pifmt_pkg::CH_SPACE;
      pifmt_pkg::SRC_MINUS: ch = pifmt_pkg::CH_MINUS;
      pifmt_pkg::SRC_ZERO:  ch = pifmt_pkg::CH_ZERO;
      pifmt_pkg::SRC_DIGIT: ch = (top < 4'd10) ? (pifmt_pkg::CH_ZERO + 8'(top))
                                               : (pifmt_pkg::CH_A + 8'(top - 4'd10));
      default:              ch = pifmt_pkg::CH_SPACE;
    endcase
    nd_eff = supp_r ? '0 : nd_r;
    core   = 7'(nd_r) + 7'(zprec_r) + 7'(neg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pifmt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (fire)               out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r      <= neg_in;
      left_r     <= in_if.left_align;
      zero_r     <= in_if.zero_pad && !in_if.precision_given;
      pgiven_r   <= in_if.precision_given;
      width_r    <= (in_if.field_width > WIDTH_MAX) ? WIDTH_MAX : in_if.field_width;
      prec_r     <= (in_if.precision > PREC_MAX) ? PREC_MAX : in_if.precision;
      supp_r     <= in_if.precision_given && (in_if.precision == '0) && (mag == 64'd0);
      nd_r       <= hex ? 5'(pifmt_pkg::HEX_DIGS) : 5'(pifmt_pkg::NDIG);
      conv_cnt_r <= hex ? 6'd0 : 6'(pifmt_pkg::DAB_STEPS);
    end
    if (dcmd.dabble) conv_cnt_r <= conv_cnt_r - 6'd1;
    if ((cw.op == pifmt_pkg::OP_NORM) && cond) nd_r <= nd_r - 5'd1;
    if (cw.op == pifmt_pkg::OP_PREC) begin
      nd_r    <= nd_eff;
      zprec_r <= (pgiven_r && (prec_r > 6'(nd_eff))) ? (prec_r - 6'(nd_eff)) : '0;
    end
    if (cw.op == pifmt_pkg::OP_PAD) begin
      // core never passes 63, so the field is the larger of width and core
      rem_r  <= (7'(width_r) > core) ? width_r : core[5:0];
      lpad_r <= (!left_r && !zero_r && (7'(width_r) > core)) ? (width_r - core[5:0]) : '0;
      zpad_r <= (!left_r && zero_r && (7'(width_r) > core)) ? (width_r - core[5:0]) : '0;
      tpad_r <= (left_r && (7'(width_r) > core)) ? (width_r - core[5:0]) : '0;
    end
    if (fire) begin
      rem_r      <= rem_r - 6'd1;
      out_char_r <= ch;
      out_last_r <= (rem_r == 6'd1);
      unique case (cw.cnd)
        pifmt_pkg::COND_LPAD:  lpad_r  <= lpad_r - 6'd1;
        pifmt_pkg::COND_SIGN:  neg_r   <= 1'b0;
        pifmt_pkg::COND_ZPAD:  zpad_r  <= zpad_r - 6'd1;
        pifmt_pkg::COND_ZPREC: zprec_r <= zprec_r - 6'd1;
        pifmt_pkg::COND_DIG:   nd_r    <= nd_r - 5'd1;
        pifmt_pkg::COND_TPAD:  tpad_r  <= tpad_r - 6'd1;
        default: ;
      endcase
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_char = out_char_r;
  assign out_if.last     = out_last_r;

endmodule

// ----- rtl/pifmt_checker.sv -----
module pifmt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // one item at a time: no second beat straight after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  // once idle again, only the final character may still be waiting
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_last)
    else $error("idle with a non-final character pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled output beat changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind printf_integer_field_formatter pifmt_checker u_pifmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_char  (out_if.out_char),
  .out_last  (out_if.last)
);

// ----- bench/tb_top.sv -----
module tb_top;

  localparam int MAX_FIELD = 63;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_FIELDS = 206;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 60;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
    logic        left_align;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic        precision_given;
    logic [5:0]  precision;
  } field_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  class field_checker;
    char_beat_t expected_chars[$];
    int errors;
    int fields_seen;
    int empty_fields;
    int chars_checked;
    int mode_seen[4];

    function int pending();
      return expected_chars.size();
    endfunction

    // works out the characters of one accepted field and queues them
    function void note_field(field_t f);
      logic [63:0] mag;
      logic [3:0]  nib;
      logic [7:0]  digs[$];
      logic [7:0]  text[$];
      int unsigned wid, prec, zprec, core, pad;
      bit neg, zfill;
      char_beat_t b;
      wid = 32'(f.field_width);
      if (wid > MAX_FIELD) wid = MAX_FIELD;
      prec = 32'(f.precision);
      if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
      // a precision cancels zero padding
      zfill = f.zero_pad && !f.precision_given;
      neg = (f.mode == pifmt_pkg::MODE_SDEC) && f.value[63];
      mag = neg ? -f.value : f.value;
      if (!(f.precision_given && prec == 0 && mag == 64'd0)) begin
        if (mag == 64'd0) begin
          digs.push_front(pifmt_pkg::CH_ZERO);
        end else if (f.mode == pifmt_pkg::MODE_HEX) begin
          while (mag != 64'd0) begin
            nib = mag[3:0];
            digs.push_front(nib < 4'd10 ? 8'(pifmt_pkg::CH_ZERO + nib)
                                        : 8'(pifmt_pkg::CH_A + nib - 4'd10));
            mag = mag >> 4;
          end
        end else begin
          while (mag != 64'd0) begin
            digs.push_front(8'(pifmt_pkg::CH_ZERO + 8'(mag % 64'd10)));
            mag = mag / 64'd10;
          end
        end
      end
      zprec = (f.precision_given && digs.size() < prec) ? prec - digs.size() : 0;
      core = digs.size() + zprec + (neg ? 1 : 0);
      pad = (wid > core) ? wid - core : 0;
      if (!f.left_align && !zfill)
        repeat (pad) text.push_back(pifmt_pkg::CH_SPACE);
      if (neg) text.push_back(pifmt_pkg::CH_MINUS);
      if (!f.left_align && zfill)
        repeat (pad) text.push_back(pifmt_pkg::CH_ZERO);
      repeat (zprec) text.push_back(pifmt_pkg::CH_ZERO);
      foreach (digs[i]) text.push_back(digs[i]);
      if (f.left_align)
        repeat (pad) text.push_back(pifmt_pkg::CH_SPACE);
      foreach (text[i]) begin
        b.ch = text[i];
        b.last = (i == text.size() - 1);
        expected_chars.push_back(b);
      end
      fields_seen++;
      mode_seen[f.mode]++;
      if (text.size() == 0) empty_fields++;
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        $error("out_char: no character expected, got 0x%02h last %0b", ch, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (ch !== want.ch) begin
        $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  field_checker sb = new();

  pifmt_in_if  in_ch();
  pifmt_out_if out_ch();

  printf_integer_field_formatter #(.MAX_FIELD(MAX_FIELD)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic field_t mk_field(logic [1:0] m, logic [63:0] v, int l, int z,
                                      int w, int pg, int p);
    field_t f;
    f.mode = m;
    f.value = v;
    f.left_align = 1'(l);
    f.zero_pad = 1'(z);
    f.field_width = 6'(w);
    f.precision_given = 1'(pg);
    f.precision = 6'(p);
    return f;
  endfunction

  task automatic send_field(input field_t f);
    int gap;
    @(negedge clk);
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode = f.mode;
    in_ch.value = f.value;
    in_ch.left_align = f.left_align;
    in_ch.zero_pad = f.zero_pad;
    in_ch.field_width = f.field_width;
    in_ch.precision_given = f.precision_given;
    in_ch.precision = f.precision;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_field(f);
  endtask

  // result side: random stalls, plus one long hold once the run is under way
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.fields_seen >= HOLD_AFTER) begin
        held = 1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        stall = gap_len() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_char(out_ch.out_char, out_ch.last);
  end

  // ends the run if neither side moves a beat for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
        quiet++;
      else
        quiet = 0;
    end
    $display("printf_integer_field_formatter test failed");
    $finish;
  end

  initial begin
    field_t      f;
    logic [63:0] v, p;
    int          r, w, pr;
    in_ch.valid = 1'b0;
    in_ch.mode = pifmt_pkg::MODE_SDEC;
    in_ch.value = '0;
    in_ch.left_align = 1'b0;
    in_ch.zero_pad = 1'b0;
    in_ch.field_width = '0;
    in_ch.precision_given = 1'b0;
    in_ch.precision = '0;
    steady = 0;
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'd0, 0, 0, 0, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 63));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, 25, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 20, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'hABCD_EF01_2345_6789, 1, 0, 20, 0, 0));
    send_field(mk_field(MODE_SPARE, 64'd12345, 0, 0, 8, 0, 0));
    send_field(mk_field(MODE_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
    // left alignment beats zero padding
    send_field(mk_field(pifmt_pkg::MODE_SDEC, -64'd42, 1, 1, 10, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, -64'd42, 0, 1, 10, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, -64'd42, 0, 1, 10, 1, 5));
    // zero with precision zero prints no digits, possibly nothing at all
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'd0, 0, 0, 0, 1, 0));
    send_field(mk_field(pifmt_pkg::MODE_UDEC, 64'd0, 0, 1, 5, 1, 0));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'd0, 1, 0, 4, 1, 0));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'd0, 0, 0, 0, 1, 0));
    // precision 63 saturates at 62, field never exceeds 63 characters
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 63, 1, 63));
    send_field(mk_field(pifmt_pkg::MODE_UDEC, 64'd7, 0, 0, 63, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'd1, 0, 1, 63, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 63, 1, 63));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, 64'd0, 0, 0, 0, 1, 1));
    send_field(mk_field(pifmt_pkg::MODE_HEX, 64'h0A, 1, 0, 3, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_SDEC, -64'd123456, 0, 1, 3, 0, 0));
    send_field(mk_field(pifmt_pkg::MODE_UDEC, 64'd0, 0, 1, 6, 0, 0));

    for (int k = 0; k < RANDOM_FIELDS; k++) begin
      steady = (k % 48) >= 36;
      r = $urandom_range(0, 9);
      f.mode = (r < 4) ? pifmt_pkg::MODE_SDEC : (r < 7) ? pifmt_pkg::MODE_UDEC :
               (r < 9) ? pifmt_pkg::MODE_HEX : MODE_SPARE;
      case ($urandom_range(0, 7))
        0: v = 64'd0;
        1: v = 64'($urandom_range(0, 999));
        2: v = {$urandom, $urandom};
        3: v = -64'($urandom_range(1, 99999));
        4: begin
          // around a power of ten, where the digit count changes
          p = 64'd1;
          repeat ($urandom_range(1, 19)) p = p * 64'd10;
          v = p - 64'($urandom_range(0, 1));
          if ($urandom_range(0, 1) == 0) v = -v;
        end
        5: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        6: begin
          case ($urandom_range(0, 2))
            0: v = 64'hFFFF_FFFF_FFFF_FFFF;
            1: v = 64'h8000_0000_0000_0000;
            default: v = 64'h7FFF_FFFF_FFFF_FFFF;
          endcase
        end
        default: v = 64'($urandom);
      endcase
      f.value = v;
      f.left_align = 1'($urandom_range(0, 1));
      f.zero_pad = 1'($urandom_range(0, 1));
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 63) : $urandom_range(0, 24);
      pr = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 63) : $urandom_range(0, 25);
      f.field_width = 6'(w);
      f.precision = 6'(pr);
      f.precision_given = ($urandom_range(0, 2) == 0);
      send_field(f);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    steady = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("fields formatted: %0d (%0d empty), characters checked: %0d",
             sb.fields_seen, sb.empty_fields, sb.chars_checked);
    $display("by mode: signed %0d, unsigned %0d, hex %0d, spare %0d; output held off %0d cycles",
             sb.mode_seen[pifmt_pkg::MODE_SDEC], sb.mode_seen[pifmt_pkg::MODE_UDEC],
             sb.mode_seen[pifmt_pkg::MODE_HEX], sb.mode_seen[MODE_SPARE], HOLD_CYCLES);
    if (sb.errors == 0)
      $display("printf_integer_field_formatter test passed");
    else
      $display("printf_integer_field_formatter test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pifmt_pkg.sv
rtl/pifmt_if.sv
rtl/pifmt_digits.sv
rtl/printf_integer_field_formatter.sv
rtl/pifmt_checker.sv
bench/tb_top.sv
